// ===== hw/rtl/lrfc_pkg.sv =====
// Shared types and codes for the log ring flush controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lrfc_pkg;

   // Operation codes carried by an input beat.
   typedef enum logic [1:0] {
      OP_LOG      = 2'd0,
      OP_POLL     = 2'd1,
      OP_FLUSH    = 2'd2,
      OP_COMPLETE = 2'd3
   } op_type;

   // Result kinds carried by an output beat.
   typedef enum logic [2:0] {
      KIND_GRANT   = 3'd0,
      KIND_ISSUED  = 3'd1,
      KIND_DROPPED = 3'd2,
      KIND_NONE    = 3'd3,
      KIND_ACK     = 3'd4
   } kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_DISCARD_POLICY  = 2'd0,
      CSR_FLUSH_THRESHOLD = 2'd1,
      CSR_IDLE_TIMEOUT    = 2'd2,
      CSR_SENDER_PRESENT  = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_WIDTH = 32;

   // Configuration register file contents.
   typedef struct packed {
      logic        discard_policy;
      logic [6:0]  flush_threshold;
      logic [31:0] idle_timeout;
      logic        sender_present;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      kind_type   kind;
      logic       granted;
      logic [5:0] slot_index;
      logic [6:0] run_length;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lrfc_engine.sv =====
// Ring pointer state and the per-item decision logic of the flush controller.
// Depends on lrfc_pkg for the operation codes, result kinds and result struct.
`timescale 1ns / 1ps
`default_nettype none

module lrfc_engine #(
   parameter int RING_DEPTH = 64,
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire lrfc_pkg::op_type    op,
   input  wire logic [31:0]         now,
   input  wire logic [6:0]          done_entries,
   input  wire lrfc_pkg::cfg_type   cfg,
   output logic [1:0]               push_cnt,
   output lrfc_pkg::result_type     res0,
   output lrfc_pkg::result_type     res1
);
   import lrfc_pkg::*;

   localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int TW = TIME_WIDTH;
   localparam int SW = (PW > 6) ? PW : 6;
   localparam int LW = (CW > 7) ? CW : 7;
   localparam int NW = (TW > 32) ? TW : 32;
   localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);
   localparam logic [CW:0]   DEPTH_C1 = (CW + 1)'(RING_DEPTH);

   typedef struct packed {
      logic [PW-1:0] wp;
      logic [PW-1:0] rp;
      logic [CW-1:0] vc;
      logic          busy;
   } ring_type;

   typedef struct packed {
      logic          ok;
      logic [PW-1:0] start;
      logic [CW-1:0] n;
      ring_type      st;
   } flush_type;

   ring_type      ring_ff, ring_in;
   logic [TW-1:0] last_time_ff, last_time_in;

   // Pointer advance with one wrap; the sum stays below twice the depth.
   function automatic logic [PW-1:0] ring_adv(input logic [PW-1:0] p,
                                               input logic [CW-1:0] n);
      logic [CW:0] sum;
      sum = (CW + 1)'(p) + (CW + 1)'(n);
      if (sum >= DEPTH_C1) begin
         sum = sum - DEPTH_C1;
      end
      return sum[PW-1:0];
   endfunction

   // One flush attempt: the contiguous run from the read pointer.
   function automatic flush_type try_flush(input ring_type s, input logic sender);
      flush_type     f;
      logic [CW-1:0] n_raw;
      f.ok    = !s.busy && (s.vc != '0);
      f.start = s.rp;
      f.st    = s;
      if (s.rp < s.wp) begin
         n_raw = CW'(s.wp) - CW'(s.rp);
      end else begin
         n_raw = DEPTH_C - CW'(s.rp);
      end
      f.n = (n_raw > s.vc) ? s.vc : n_raw;
      if (f.ok) begin
         if (sender) begin
            f.st.busy = 1'b1;
         end else begin
            f.st.rp = ring_adv(s.rp, f.n);
            f.st.vc = s.vc - f.n;
         end
      end
      return f;
   endfunction

   // Pack a result beat, masking the slot and length to the port widths.
   function automatic result_type make_res(input kind_type k, input logic g,
                                           input logic [PW-1:0] slot,
                                           input logic [CW-1:0] len);
      result_type    r;
      logic [SW-1:0] slot_x;
      logic [LW-1:0] len_x;
      slot_x       = SW'(slot);
      len_x        = LW'(len);
      r.kind       = k;
      r.granted    = g;
      r.slot_index = slot_x[5:0];
      r.run_length = len_x[6:0];
      r.last       = 1'b0;
      return r;
   endfunction

   logic [NW-1:0] now_x;
   logic [TW-1:0] now_t;
   logic [TW-1:0] idle_diff;
   logic          thr_hit;
   logic          idle_hit;
   flush_type     fl_a;
   flush_type     fl_b;
   ring_type      after_a;
   logic [LW-1:0] done_x;
   logic [CW-1:0] done_n;
   result_type    r0, r1;
   logic [1:0]    cnt;

   // Trigger conditions for the poll.
   always_comb begin
      now_x     = NW'(now);
      now_t     = now_x[TW-1:0];
      idle_diff = now_t - last_time_ff;
      thr_hit   = (cfg.flush_threshold != '0) &&
                  (LW'(ring_ff.vc) >= LW'(cfg.flush_threshold));
      idle_hit  = (cfg.idle_timeout != '0) &&
                  (NW'(idle_diff) > NW'(cfg.idle_timeout));
      done_x    = LW'(done_entries);
      done_n    = (done_x > LW'(ring_ff.vc)) ? ring_ff.vc : done_x[CW-1:0];
   end

   // The second poll flush sees the state left by the first.
   always_comb begin
      fl_a    = try_flush(ring_ff, cfg.sender_present);
      after_a = (thr_hit && fl_a.ok) ? fl_a.st : ring_ff;
      fl_b    = try_flush(after_a, cfg.sender_present);
   end

   // Decode the operation into the next state and up to two result beats.
   always_comb begin
      ring_in      = ring_ff;
      last_time_in = last_time_ff;
      r0           = make_res(KIND_NONE, 1'b0, '0, '0);
      r1           = make_res(KIND_NONE, 1'b0, '0, '0);
      cnt          = 2'd0;
      unique case (op)
         OP_LOG: begin
            last_time_in = now_t;
            cnt          = 2'd1;
            if (ring_ff.vc < DEPTH_C) begin
               r0         = make_res(KIND_GRANT, 1'b1, ring_ff.wp, '0);
               ring_in.wp = ring_adv(ring_ff.wp, CW'(1));
               ring_in.vc = ring_ff.vc + CW'(1);
            end else if (cfg.discard_policy) begin
               r0 = make_res(KIND_GRANT, 1'b0, '0, '0);
            end else begin
               r0         = make_res(KIND_GRANT, 1'b1, ring_ff.wp, '0);
               ring_in.wp = ring_adv(ring_ff.wp, CW'(1));
               ring_in.rp = ring_adv(ring_ff.rp, CW'(1));
            end
         end
         OP_POLL: begin
            if (thr_hit && fl_a.ok) begin
               r0      = make_res(cfg.sender_present ? KIND_ISSUED : KIND_DROPPED,
                                  1'b0, fl_a.start, fl_a.n);
               ring_in = fl_a.st;
               cnt     = 2'd1;
            end
            if (idle_hit && fl_b.ok) begin
               if (cnt == 2'd1) begin
                  r1  = make_res(cfg.sender_present ? KIND_ISSUED : KIND_DROPPED,
                                 1'b0, fl_b.start, fl_b.n);
                  cnt = 2'd2;
               end else begin
                  r0  = make_res(cfg.sender_present ? KIND_ISSUED : KIND_DROPPED,
                                 1'b0, fl_b.start, fl_b.n);
                  cnt = 2'd1;
               end
               ring_in = fl_b.st;
            end
         end
         OP_FLUSH: begin
            if (fl_a.ok) begin
               r0      = make_res(cfg.sender_present ? KIND_ISSUED : KIND_DROPPED,
                                  1'b0, fl_a.start, fl_a.n);
               ring_in = fl_a.st;
               cnt     = 2'd1;
            end
         end
         OP_COMPLETE: begin
            if (ring_ff.busy) begin
               r0           = make_res(KIND_ACK, 1'b0, ring_ff.rp, done_n);
               ring_in.rp   = ring_adv(ring_ff.rp, done_n);
               ring_in.vc   = ring_ff.vc - done_n;
               ring_in.busy = 1'b0;
               cnt          = 2'd1;
            end
         end
         default: begin
            cnt = 2'd0;
         end
      endcase
      // An item that did nothing still answers with one beat.
      if (cnt == 2'd0) begin
         cnt = 2'd1;
      end
      if (cnt == 2'd2) begin
         r1.last = 1'b1;
      end else begin
         r0.last = 1'b1;
      end
   end

   assign res0     = r0;
   assign res1     = r1;
   assign push_cnt = fire ? cnt : 2'd0;

   // State registers advance only when an item is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff      <= '0;
         last_time_ff <= '0;
      end else if (fire) begin
         ring_ff      <= ring_in;
         last_time_ff <= last_time_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lrfc_result_fifo.sv =====
// Four-entry result queue that takes up to two beats a cycle and gives one while out_stall is low.
// Depends on lrfc_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module lrfc_result_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [1:0]           push_cnt,
   input  wire lrfc_pkg::result_type push0,
   input  wire lrfc_pkg::result_type push1,
   output logic                      room_two,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output lrfc_pkg::result_type      out_data
);
   import lrfc_pkg::*;

   result_type entries_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign room_two  = (count_ff <= 3'd2);
   assign pop       = out_valid && !out_stall;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_cnt;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_cnt} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage; no reset needed.
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         entries_ff[wr_ptr_ff + 2'd1] <= push1;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/log_ring_flush_controller_unit.sv =====
// Top level of the log ring flush controller: input register, configuration
// registers, decision engine and result queue. Depends on lrfc_pkg,
// lrfc_engine and lrfc_result_fifo.
//
// Usage:
//  - The req_ channel carries one item per beat: an operation (log, poll,
//    flush request, transfer completion), a timestamp and a completion count.
//  - The rsp_ channel returns one or two result beats per item, in order;
//    rsp_last marks the final beat of an item. Only a poll that fires both
//    the threshold and the idle trigger without a sender yields two beats.
//  - The csr_ port writes the four configuration registers; the user must
//    write them only while idle, as the block itself does not enforce it.
//  - Path: an accepted item is held in the input register, evaluated by the
//    engine and written to the result queue, which presents its result beats.
//  - Throughput: one item per cycle through a single decision pass while
//    req_stall is low; a two-beat item leaves the result port beat by beat.
//  - When rsp_stall is high, the result queue fills; once it cannot take
//    two more beats the input register holds and req_stall rises.
//  - Reset clears the ring state, the configuration, the input register
//    and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module log_ring_flush_controller_unit #(
   parameter int RING_DEPTH = 64,
   parameter int TIME_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_now,
   input  wire logic [6:0]  req_completed_entries,
   // Result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic             rsp_granted,
   output logic [5:0]       rsp_slot_index,
   output logic [6:0]       rsp_run_length,
   output logic             rsp_last,
   // Configuration port
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [lrfc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import lrfc_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff, in_valid_in;
   op_type     op_ff;
   logic [31:0] now_ff;
   logic [6:0] done_ff;
   logic       accept;
   logic       fire;
   logic       room_two;
   logic [1:0] push_cnt;
   result_type res0, res1;
   result_type head;

   // Input register: holds while the result queue lacks room.
   assign fire        = in_valid_ff && room_two;
   assign req_stall   = in_valid_ff && !room_two;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_op);
         now_ff  <= req_now;
         done_ff <= req_completed_entries;
      end
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DISCARD_POLICY:  cfg_ff.discard_policy  <= csr_wdata[0];
            CSR_FLUSH_THRESHOLD: cfg_ff.flush_threshold <= csr_wdata[6:0];
            CSR_IDLE_TIMEOUT:    cfg_ff.idle_timeout    <= csr_wdata;
            CSR_SENDER_PRESENT:  cfg_ff.sender_present  <= csr_wdata[0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   lrfc_engine #(
      .RING_DEPTH (RING_DEPTH),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .op           (op_ff),
      .now          (now_ff),
      .done_entries (done_ff),
      .cfg          (cfg_ff),
      .push_cnt     (push_cnt),
      .res0         (res0),
      .res1         (res1)
   );

   lrfc_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (res0),
      .push1     (res1),
      .room_two  (room_two),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   // Result beat fields.
   assign rsp_kind       = head.kind;
   assign rsp_granted    = head.granted;
   assign rsp_slot_index = head.slot_index;
   assign rsp_run_length = head.run_length;
   assign rsp_last       = head.last;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for log_ring_flush_controller_unit: a scoreboard class
// predicts every result beat, and tasks drive the req_ and csr_ ports.
// Depends on lrfc_pkg and the RTL of the block.
`timescale 1ns / 1ps

import lrfc_pkg::*;

// Tracks the ring pointers and registers, and holds the result beats still owed.
class ring_pointer_scoreboard;
   localparam int RING_SLOTS = 64;
   localparam int PRINT_CAP  = 50;

   // Copy of the configuration registers.
   logic        discard_policy;
   logic [6:0]  flush_threshold;
   logic [31:0] idle_timeout;
   logic        sender_present;

   // Copy of the pointer state.
   logic [5:0]  wr_ptr;
   logic [5:0]  rd_ptr;
   logic [6:0]  fill;
   logic [31:0] last_log_time;
   logic        busy;
   logic [6:0]  issued_len;

   result_type  pending_results[$];
   int unsigned error_count;

   function new();
      discard_policy  = 1'b0;
      flush_threshold = '0;
      idle_timeout    = '0;
      sender_present  = 1'b0;
      wr_ptr          = '0;
      rd_ptr          = '0;
      fill            = '0;
      last_log_time   = '0;
      busy            = 1'b0;
      issued_len      = '0;
      error_count     = 0;
   endfunction

   function void write_register(csr_index_type idx, logic [31:0] data);
      case (idx)
         CSR_DISCARD_POLICY:  discard_policy  = data[0];
         CSR_FLUSH_THRESHOLD: flush_threshold = data[6:0];
         CSR_IDLE_TIMEOUT:    idle_timeout    = data;
         CSR_SENDER_PRESENT:  sender_present  = data[0];
         default: ;
      endcase
   endfunction

   function result_type make_beat(kind_type kind, logic granted, logic [5:0] slot,
                                  logic [6:0] run);
      result_type beat;
      beat.kind       = kind;
      beat.granted    = granted;
      beat.slot_index = slot;
      beat.run_length = run;
      beat.last       = 1'b0;
      return beat;
   endfunction

   // One flush attempt: only the unwrapped run from the read pointer is taken.
   function bit try_flush(output result_type beat);
      int run;
      beat = make_beat(KIND_NONE, 1'b0, '0, '0);
      if (busy || fill == 0)
         return 1'b0;
      if (rd_ptr < wr_ptr)
         run = wr_ptr - rd_ptr;
      else
         run = RING_SLOTS - rd_ptr;
      if (run > fill)
         run = fill;
      if (sender_present) begin
         busy       = 1'b1;
         issued_len = 7'(run);
         beat       = make_beat(KIND_ISSUED, 1'b0, rd_ptr, 7'(run));
      end else begin
         beat   = make_beat(KIND_DROPPED, 1'b0, rd_ptr, 7'(run));
         rd_ptr = rd_ptr + 6'(run);
         fill   = fill - 7'(run);
      end
      return 1'b1;
   endfunction

   // Works out the result beats of one accepted input beat and queues them.
   function void note_request(op_type op, logic [31:0] stamp, logic [6:0] count);
      result_type  beats [2];
      int          n_beats;
      int          done;
      logic [31:0] idle_ticks;
      n_beats = 0;
      case (op)
         OP_LOG: begin
            last_log_time = stamp;
            if (fill < RING_SLOTS) begin
               beats[0] = make_beat(KIND_GRANT, 1'b1, wr_ptr, '0);
               wr_ptr++;
               fill++;
            end else if (discard_policy) begin
               beats[0] = make_beat(KIND_GRANT, 1'b0, '0, '0);
            end else begin
               // Full ring under overwrite: the oldest entry goes.
               beats[0] = make_beat(KIND_GRANT, 1'b1, wr_ptr, '0);
               wr_ptr++;
               rd_ptr++;
            end
            n_beats = 1;
         end
         OP_POLL: begin
            if (flush_threshold != 0 && fill >= flush_threshold)
               n_beats += try_flush(beats[n_beats]);
            idle_ticks = stamp - last_log_time;
            if (idle_timeout != 0 && idle_ticks > idle_timeout)
               n_beats += try_flush(beats[n_beats]);
         end
         OP_FLUSH: begin
            n_beats += try_flush(beats[0]);
         end
         OP_COMPLETE: begin
            // A completion is ignored unless a transfer is out.
            if (busy) begin
               done = count;
               if (done > fill)
                  done = fill;
               beats[0] = make_beat(KIND_ACK, 1'b0, rd_ptr, 7'(done));
               rd_ptr   = rd_ptr + 6'(done);
               fill     = fill - 7'(done);
               busy     = 1'b0;
               n_beats  = 1;
            end
         end
         default: ;
      endcase
      if (n_beats == 0) begin
         beats[0] = make_beat(KIND_NONE, 1'b0, '0, '0);
         n_beats  = 1;
      end
      beats[n_beats - 1].last = 1'b1;
      for (int i = 0; i < n_beats; i++)
         pending_results.push_back(beats[i]);
   endfunction

   task report_mismatch(string msg);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("[%0t] ERROR: %s", $time, msg);
   endtask

   task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Compares one accepted result beat with the oldest one owed.
   task check_result(result_type got);
      result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result beat of kind %0d with nothing expected",
                                   got.kind));
         return;
      end
      want = pending_results.pop_front();
      compare_field("kind", 32'(got.kind), 32'(want.kind));
      compare_field("granted", 32'(got.granted), 32'(want.granted));
      compare_field("slot_index", 32'(got.slot_index), 32'(want.slot_index));
      compare_field("run_length", 32'(got.run_length), 32'(want.run_length));
      compare_field("last", 32'(got.last), 32'(want.last));
   endtask
endclass

module tb_top;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_BEATS = 50;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [31:0] req_now;
   logic [6:0]  req_completed_entries;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic        rsp_granted;
   logic [5:0]  rsp_slot_index;
   logic [6:0]  rsp_run_length;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;

   ring_pointer_scoreboard sb;

   log_ring_flush_controller_unit DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_now               (req_now),
      .req_completed_entries (req_completed_entries),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_kind              (rsp_kind),
      .rsp_granted           (rsp_granted),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_run_length        (rsp_run_length),
      .rsp_last              (rsp_last),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   // Random back-pressure on the result channel.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Every accepted result beat goes to the scoreboard.
   always @(posedge clock) begin
      result_type beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         beat.kind       = kind_type'(rsp_kind);
         beat.granted    = rsp_granted;
         beat.slot_index = rsp_slot_index;
         beat.run_length = rsp_run_length;
         beat.last       = rsp_last;
         sb.check_result(beat);
      end
   end

   // Ends the run when neither channel nor the register port moves for too long.
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 59; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 59; end
         default:       begin send_idle_pct = 27; stall_pct = 27; end
      endcase
   endtask

   // Presents one input beat after an optional gap and waits until it is taken.
   task automatic send_item(input op_type op, input logic [31:0] stamp,
                            input logic [6:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_op                <= op;
      req_now               <= stamp;
      req_completed_entries <= count;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, stamp, count);
   endtask

   // Random beat; completions are favoured while an issued transfer is out.
   task automatic send_random(input int log_pct);
      op_type      op;
      logic [31:0] stamp;
      logic [6:0]  count;
      int          pick;
      pick = $urandom_range(99);
      if (sb.busy && pick < 45) begin
         op = OP_COMPLETE;
      end else begin
         pick = $urandom_range(99);
         if (pick < log_pct)
            op = OP_LOG;
         else if (pick < log_pct + (100 - log_pct) / 2)
            op = OP_POLL;
         else if (pick < log_pct + 3 * (100 - log_pct) / 4)
            op = OP_FLUSH;
         else
            op = OP_COMPLETE;
      end
      // Timestamps land near the idle limit, close behind the last log, or anywhere.
      case ($urandom_range(5))
         0:       stamp = $urandom();
         1, 2:    stamp = sb.last_log_time + sb.idle_timeout + 32'($urandom_range(2)) - 32'd1;
         default: stamp = sb.last_log_time + 32'($urandom_range(64));
      endcase
      case ($urandom_range(6))
         0, 1, 2: count = sb.issued_len;
         3:       count = 7'd0;
         4:       count = 7'd64;
         default: count = 7'($urandom_range(64));
      endcase
      send_item(op, stamp, count);
   endtask

   // Lets every owed result arrive and the pipeline empty before a register write.
   task automatic settle;
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_register(input csr_index_type idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   task automatic apply_settings(input logic discard, input logic [6:0] threshold,
                                 input logic [31:0] timeout, input logic sender);
      put_register(CSR_DISCARD_POLICY, {31'd0, discard});
      put_register(CSR_FLUSH_THRESHOLD, {25'd0, threshold});
      put_register(CSR_IDLE_TIMEOUT, timeout);
      put_register(CSR_SENDER_PRESENT, {31'd0, sender});
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic discard, input logic [6:0] threshold,
                            input logic [31:0] timeout, input logic sender,
                            input int log_pct, input idle_mode_type mode);
      settle();
      apply_settings(discard, threshold, timeout, sender);
      set_idle_mode(mode);
      repeat (PHASE_BEATS) send_random(log_pct);
   endtask

   initial begin
      sb = new();
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_op                <= OP_LOG;
      req_now               <= '0;
      req_completed_entries <= '0;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_DISCARD_POLICY;
      csr_wdata             <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: completion while idle, empty ring, drop without a sender.
      send_item(OP_COMPLETE, 32'h0, 7'd64);
      send_item(OP_POLL, 32'hFFFF_FFFF, 7'd0);
      send_item(OP_FLUSH, 32'h0, 7'd0);
      send_item(OP_LOG, 32'hFFFF_FFFF, 7'd0);
      send_item(OP_LOG, 32'h0, 7'd0);
      send_item(OP_FLUSH, 32'h0, 7'd0);

      // Threshold at the ring depth and largest timeout with a sender: busy transfer, saturated count.
      settle();
      apply_settings(1'b1, 7'd64, 32'hFFFF_FFFF, 1'b1);
      send_item(OP_LOG, 32'h0, 7'd0);
      send_item(OP_POLL, 32'hFFFF_FFFF, 7'd0);
      send_item(OP_FLUSH, 32'h0, 7'd0);
      send_item(OP_FLUSH, 32'h0, 7'd0);
      send_item(OP_LOG, 32'h5, 7'd0);
      send_item(OP_COMPLETE, 32'h0, 7'd64);
      send_item(OP_FLUSH, 32'h0, 7'd0);
      send_item(OP_COMPLETE, 32'h0, 7'd0);

      // Smallest nonzero triggers without a sender, with a wrapped time difference.
      settle();
      apply_settings(1'b0, 7'd1, 32'd1, 1'b0);
      send_item(OP_LOG, 32'd100, 7'd0);
      send_item(OP_POLL, 32'd99, 7'd0);
      send_item(OP_LOG, 32'd200, 7'd0);
      send_item(OP_POLL, 32'd201, 7'd0);
      send_item(OP_POLL, 32'd202, 7'd0);

      // Random phases sweeping the register settings and the idling patterns.
      run_phase(1'b0, 7'd64, 32'd5000, 1'b0, 80, IDLE_NONE);
      run_phase(1'b1, 7'd0, 32'hFFFF_FFFF, 1'b1, 80, IDLE_SENDER);
      run_phase(1'b1, 7'd8, 32'd1000, 1'b0, 55, IDLE_RECEIVER);
      run_phase(1'b0, 7'd3, 32'd50, 1'b1, 55, IDLE_BOTH);
      run_phase(1'b0, 7'd1, 32'd1, 1'b0, 60, IDLE_NONE);
      run_phase(1'b1, 7'd64, 32'h8000_0000, 1'b1, 70, IDLE_RECEIVER);
      run_phase(1'b0, 7'd20, 32'd0, 1'b1, 55, IDLE_SENDER);
      run_phase(1'b1, 7'd0, 32'd0, 1'b0, 85, IDLE_BOTH);

      // Drain, then leave room for any stray beat to show up.
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/lrfc_pkg.sv
hw/rtl/lrfc_engine.sv
hw/rtl/lrfc_result_fifo.sv
hw/rtl/log_ring_flush_controller_unit.sv
dv/tb_top.sv
